>>> rtl/core/dnsc_pkg.sv
// Package: character classes, register indexes and constants for the hostname checker.
package dnsc_pkg;

    typedef enum logic [1:0] {
        CLASS_START  = 2'd0,
        CLASS_DOT    = 2'd1,
        CLASS_HYPHEN = 2'd2,
        CLASS_ALNUM  = 2'd3
    } class_t;

    typedef enum logic {
        REG_MAX_NAME_LENGTH  = 1'b0,
        REG_MAX_LABEL_LENGTH = 1'b1
    } reg_index_t;

    localparam logic [7:0] MAX_NAME_RESET  = 8'd253;
    localparam logic [5:0] MAX_LABEL_RESET = 6'd63;
    localparam logic [7:0] NAME_SAT        = 8'd255;
    localparam logic [6:0] LABEL_SAT       = 7'd127;
    localparam logic [6:0] MIN_LAST_LABEL  = 7'd2;

    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UZ     = 8'h5A;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LZ     = 8'h7A;

endpackage

>>> rtl/core/domain_name_syntax_check_top.sv
// Top level: hostname syntax checker, one character per request, verdict on the last one.
// The verdict is registered when the request marked last leaves the input register.
// Throughput: one request per cycle, sustained, as long as results are taken.
// The input register and the result register each accept while the next stage drains.
// Reset clears the name state and loads max_name_length 253 and max_label_length 63.
// Name state also returns to its reset values after every verdict.
module domain_name_syntax_check_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [7:0] character,
    input  logic       char_present,
    input  logic       last,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       valid_res,
    output logic [7:0] name_length
);

    logic [7:0] max_name_reg;
    logic [5:0] max_label_reg;

    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       in_present_reg;
    logic       in_last_reg;

    logic [7:0]      total_count_reg, total_count_next;
    logic [6:0]      label_length_reg, label_length_next;
    dnsc_pkg::class_t prev_reg, prev_next;
    logic            all_digits_reg, all_digits_next;
    logic            dot_seen_reg, dot_seen_next;
    logic            violation_reg, violation_next;
    logic            too_long_reg, too_long_next;

    logic       out_vld_reg;
    logic       out_ok_reg, out_ok_next;
    logic [7:0] out_len_reg;

    logic [7:0]      tc_upd;
    logic [6:0]      ll_upd;
    dnsc_pkg::class_t prev_upd;
    logic            ad_upd, ds_upd, viol_upd, tl_upd;
    logic            is_digit, is_alpha;
    logic            adv;

    assign adv       = in_vld_reg && (!in_last_reg || !out_vld_reg || result_ready);
    assign req_ready = !in_vld_reg || adv;

    assign result_valid = out_vld_reg;
    assign valid_res    = out_ok_reg;
    assign name_length  = out_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_name_reg  <= dnsc_pkg::MAX_NAME_RESET;
            max_label_reg <= dnsc_pkg::MAX_LABEL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (dnsc_pkg::reg_index_t'(cfg_index))
                dnsc_pkg::REG_MAX_NAME_LENGTH:  max_name_reg  <= cfg_data;
                dnsc_pkg::REG_MAX_LABEL_LENGTH: max_label_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // hold the request until the update stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            in_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            in_char_reg    <= character;
            in_present_reg <= char_present;
            in_last_reg    <= last;
        end
    end

    always_comb
    begin
        is_digit = (in_char_reg >= dnsc_pkg::CHAR_0) && (in_char_reg <= dnsc_pkg::CHAR_9);
        is_alpha = ((in_char_reg >= dnsc_pkg::CHAR_UA) && (in_char_reg <= dnsc_pkg::CHAR_UZ)) ||
                   ((in_char_reg >= dnsc_pkg::CHAR_LA) && (in_char_reg <= dnsc_pkg::CHAR_LZ));

        tc_upd   = total_count_reg;
        ll_upd   = label_length_reg;
        prev_upd = prev_reg;
        ad_upd   = all_digits_reg;
        ds_upd   = dot_seen_reg;
        viol_upd = violation_reg;
        tl_upd   = too_long_reg;

        if (in_present_reg)
        begin
            if (total_count_reg != dnsc_pkg::NAME_SAT)
            begin
                tc_upd = total_count_reg + 8'd1;
            end
            if (tc_upd > max_name_reg)
            begin
                tl_upd = 1'b1;
            end

            if (in_char_reg == dnsc_pkg::CHAR_DOT)
            begin
                if (prev_reg != dnsc_pkg::CLASS_ALNUM)
                begin
                    viol_upd = 1'b1;
                end
                ds_upd   = 1'b1;
                ll_upd   = '0;
                ad_upd   = 1'b1;
                prev_upd = dnsc_pkg::CLASS_DOT;
            end
            else
            begin
                if (label_length_reg != dnsc_pkg::LABEL_SAT)
                begin
                    ll_upd = label_length_reg + 7'd1;
                end
                if (ll_upd > {1'b0, max_label_reg})
                begin
                    viol_upd = 1'b1;
                end
                if (in_char_reg == dnsc_pkg::CHAR_HYPHEN)
                begin
                    if (prev_reg == dnsc_pkg::CLASS_START || prev_reg == dnsc_pkg::CLASS_DOT)
                    begin
                        viol_upd = 1'b1;
                    end
                    ad_upd   = 1'b0;
                    prev_upd = dnsc_pkg::CLASS_HYPHEN;
                end
                else
                begin
                    if (!is_digit && !is_alpha)
                    begin
                        viol_upd = 1'b1;
                    end
                    if (!is_digit)
                    begin
                        ad_upd = 1'b0;
                    end
                    prev_upd = dnsc_pkg::CLASS_ALNUM;
                end
            end
        end

        out_ok_next = !viol_upd && !tl_upd && (tc_upd != 8'd0) && ds_upd &&
                      (prev_upd == dnsc_pkg::CLASS_ALNUM) &&
                      (ll_upd >= dnsc_pkg::MIN_LAST_LABEL) && !ad_upd;

        // drop the name state after a verdict
        if (in_last_reg)
        begin
            total_count_next  = '0;
            label_length_next = '0;
            prev_next         = dnsc_pkg::CLASS_START;
            all_digits_next   = 1'b1;
            dot_seen_next     = 1'b0;
            violation_next    = 1'b0;
            too_long_next     = 1'b0;
        end
        else
        begin
            total_count_next  = tc_upd;
            label_length_next = ll_upd;
            prev_next         = prev_upd;
            all_digits_next   = ad_upd;
            dot_seen_next     = ds_upd;
            violation_next    = viol_upd;
            too_long_next     = tl_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_count_reg  <= '0;
            label_length_reg <= '0;
            prev_reg         <= dnsc_pkg::CLASS_START;
            all_digits_reg   <= 1'b1;
            dot_seen_reg     <= 1'b0;
            violation_reg    <= 1'b0;
            too_long_reg     <= 1'b0;
        end
        else if (adv)
        begin
            total_count_reg  <= total_count_next;
            label_length_reg <= label_length_next;
            prev_reg         <= prev_next;
            all_digits_reg   <= all_digits_next;
            dot_seen_reg     <= dot_seen_next;
            violation_reg    <= violation_next;
            too_long_reg     <= too_long_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv && in_last_reg)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_last_reg)
        begin
            out_ok_reg  <= out_ok_next;
            out_len_reg <= tc_upd;
        end
    end

    a_verdict_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_last_reg) |=> out_vld_reg)
        else $error("verdict not registered after last request");

    a_state_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_last_reg) |=> (total_count_reg == 8'd0 && !violation_reg && !too_long_reg))
        else $error("name state not cleared after verdict");

    a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (prev_reg == dnsc_pkg::CLASS_START) == (total_count_reg == 8'd0))
        else $error("start class and character count disagree");

    a_dot_label: assert property (@(posedge clk) disable iff (!rst_n)
        (prev_reg == dnsc_pkg::CLASS_DOT) |-> (label_length_reg == 7'd0 && dot_seen_reg))
        else $error("label state wrong after dot");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> req_ready)
        else $error("empty input register refuses request");

endmodule

>>> tb/domain_name_syntax_check_top_test.sv
// Testbench for the hostname syntax checker: directed and random names checked against a local model.
module domain_name_syntax_check_top_test;

    localparam int NUM_ROWS = 25;
    localparam int NUM_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [7:0] ch;
        logic       present;
        logic       last;
    } request_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] len;
    } verdict_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        verdict_t verdict;
    } row_t;

    localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{1'b0, 8'd0}},
        '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{"x", 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{dnsc_pkg::CHAR_HYPHEN, 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{"9", 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{dnsc_pkg::CHAR_DOT, 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{"a", 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{"b", 1'b1, 1'b1}, 1'b0, '{1'b0, 8'd0}},
        '{'{8'h00, 1'b1, 1'b1}, 1'b1, '{1'b0, 8'd1}},
        '{'{8'hFF, 1'b1, 1'b1}, 1'b1, '{1'b0, 8'd1}},
        '{'{dnsc_pkg::CHAR_DOT, 1'b1, 1'b1}, 1'b1, '{1'b0, 8'd1}},
        '{'{"9", 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{dnsc_pkg::CHAR_DOT, 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{"1", 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{"2", 1'b1, 1'b1}, 1'b0, '{1'b0, 8'd0}},
        '{'{dnsc_pkg::CHAR_HYPHEN, 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{dnsc_pkg::CHAR_DOT, 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{"Z", 1'b1, 1'b1}, 1'b0, '{1'b0, 8'd0}},
        '{'{"z", 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{dnsc_pkg::CHAR_DOT, 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{"0", 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{dnsc_pkg::CHAR_HYPHEN, 1'b1, 1'b1}, 1'b0, '{1'b0, 8'd0}},
        '{'{"q", 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{dnsc_pkg::CHAR_DOT, 1'b1, 1'b0}, 1'b0, '{1'b0, 8'd0}},
        '{'{8'h00, 1'b0, 1'b1}, 1'b0, '{1'b0, 8'd0}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data = 8'd0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    logic [7:0] character = 8'd0;
    logic       char_present = 1'b0;
    logic       last = 1'b0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic       valid_res;
    logic [7:0] name_length;

    logic [7:0] lim_name = dnsc_pkg::MAX_NAME_RESET;
    logic [5:0] lim_label = dnsc_pkg::MAX_LABEL_RESET;
    logic [7:0] name_count;
    logic [6:0] seg_len;
    dnsc_pkg::class_t prev_class;
    logic       label_digits;
    logic       dot_found;
    logic       syntax_bad;
    logic       name_over;

    verdict_t   verdicts [$];
    request_t   name_buf [$];
    verdict_t   want_v;
    int         errors = 0;
    int         idle_cycles = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    domain_name_syntax_check_top u_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_hostname();
        name_count = 8'd0;
        seg_len = 7'd0;
        prev_class = dnsc_pkg::CLASS_START;
        label_digits = 1'b1;
        dot_found = 1'b0;
        syntax_bad = 1'b0;
        name_over = 1'b0;
    endfunction

    function automatic void absorb_char(input logic [7:0] c);
        logic is_digit;
        logic is_alpha;
        is_digit = (c >= dnsc_pkg::CHAR_0 && c <= dnsc_pkg::CHAR_9);
        is_alpha = (c >= dnsc_pkg::CHAR_UA && c <= dnsc_pkg::CHAR_UZ) ||
                   (c >= dnsc_pkg::CHAR_LA && c <= dnsc_pkg::CHAR_LZ);
        if (name_count != dnsc_pkg::NAME_SAT)
            name_count = name_count + 8'd1;
        if (name_count > lim_name)
            name_over = 1'b1;
        if (c == dnsc_pkg::CHAR_DOT)
        begin
            if (prev_class != dnsc_pkg::CLASS_ALNUM)
                syntax_bad = 1'b1;
            dot_found = 1'b1;
            seg_len = 7'd0;
            label_digits = 1'b1;
            prev_class = dnsc_pkg::CLASS_DOT;
        end
        else
        begin
            if (seg_len != dnsc_pkg::LABEL_SAT)
                seg_len = seg_len + 7'd1;
            if (seg_len > {1'b0, lim_label})
                syntax_bad = 1'b1;
            if (c == dnsc_pkg::CHAR_HYPHEN)
            begin
                if (prev_class == dnsc_pkg::CLASS_START || prev_class == dnsc_pkg::CLASS_DOT)
                    syntax_bad = 1'b1;
                label_digits = 1'b0;
                prev_class = dnsc_pkg::CLASS_HYPHEN;
            end
            else
            begin
                if (!is_digit && !is_alpha)
                    syntax_bad = 1'b1;
                if (!is_digit)
                    label_digits = 1'b0;
                prev_class = dnsc_pkg::CLASS_ALNUM;
            end
        end
    endfunction

    function automatic bit step_hostname(input request_t r, output verdict_t v);
        v = '0;
        if (r.present)
            absorb_char(r.ch);
        if (!r.last)
            return 1'b0;
        v.ok = !syntax_bad && !name_over && name_count >= 8'd1 && dot_found &&
               prev_class == dnsc_pkg::CLASS_ALNUM &&
               seg_len >= dnsc_pkg::MIN_LAST_LABEL && !label_digits;
        v.len = name_count;
        clear_hostname();
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_alnum();
        case ($urandom_range(2))
            0: return 8'(dnsc_pkg::CHAR_0 + $urandom_range(9));
            1: return 8'(dnsc_pkg::CHAR_UA + $urandom_range(25));
            default: return 8'(dnsc_pkg::CHAR_LA + $urandom_range(25));
        endcase
    endfunction

    task automatic push_char(input logic [7:0] c);
        if ($urandom_range(99) < 3)
            name_buf.push_back(request_t'{8'($urandom), 1'b0, 1'b0});
        name_buf.push_back(request_t'{c, 1'b1, 1'b0});
    endtask

    task automatic add_label(input int len);
        for (int i = 0; i < len; i++)
        begin
            if (i == 0 || i == len - 1 || $urandom_range(4) != 0)
                push_char(rand_alnum());
            else
                push_char(dnsc_pkg::CHAR_HYPHEN);
        end
    endtask

    task automatic build_name(input bit long_name);
        int       n_parts;
        int       target;
        int       idx;
        request_t r;
        name_buf.delete();
        if (long_name)
        begin
            target = $urandom_range(240, 300);
            while (name_buf.size() < target)
            begin
                add_label($urandom_range(40, 63));
                push_char(dnsc_pkg::CHAR_DOT);
            end
            add_label($urandom_range(2, 5));
        end
        else if ($urandom_range(99) < 25)
        begin
            n_parts = $urandom_range(10);
            for (int k = 0; k < n_parts; k++)
            begin
                case ($urandom_range(4))
                    0, 1: push_char(rand_alnum());
                    2: push_char(dnsc_pkg::CHAR_DOT);
                    3: push_char(dnsc_pkg::CHAR_HYPHEN);
                    default: push_char(8'($urandom));
                endcase
            end
        end
        else
        begin
            n_parts = $urandom_range(2, 4);
            for (int k = 0; k < n_parts; k++)
            begin
                if (k != 0)
                    push_char(dnsc_pkg::CHAR_DOT);
                if ($urandom_range(99) < 6)
                    add_label($urandom_range(58, 66));
                else
                    add_label($urandom_range(1, 8));
            end
            if ($urandom_range(99) < 20)
            begin
                idx = $urandom_range(name_buf.size() - 1);
                r = name_buf[idx];
                r.ch = ($urandom_range(1) != 0) ? 8'($urandom) : dnsc_pkg::CHAR_DOT;
                name_buf[idx] = r;
            end
        end
        // end on the last character, or on a bare end marker
        if (name_buf.size() == 0 || $urandom_range(99) < 15)
        begin
            name_buf.push_back(request_t'{8'($urandom), 1'b0, 1'b1});
        end
        else
        begin
            r = name_buf.pop_back();
            r.last = 1'b1;
            name_buf.push_back(r);
        end
    endtask

    task automatic send_request(input request_t r, input bit typed, input verdict_t typed_v);
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        character <= r.ch;
        char_present <= r.present;
        last <= r.last;
        if (step_hostname(r, v))
            verdicts.push_back(typed ? typed_v : v);
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(input logic [7:0] name_val, input logic [7:0] label_data);
        cfg_we <= 1'b1;
        cfg_index <= dnsc_pkg::REG_MAX_NAME_LENGTH;
        cfg_data <= name_val;
        @(posedge clk);
        cfg_index <= dnsc_pkg::REG_MAX_LABEL_LENGTH;
        cfg_data <= label_data;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_name = name_val;
        lim_label = label_data[5:0];
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (verdicts.size() == 0)
            begin
                $display("%0t unexpected result: valid_res %0b name_length %0d",
                         $time, valid_res, name_length);
                errors++;
            end
            else
            begin
                want_v = verdicts.pop_front();
                if (valid_res !== want_v.ok)
                begin
                    $display("%0t valid_res mismatch: expected %0b actual %0b",
                             $time, want_v.ok, valid_res);
                    errors++;
                end
                if (name_length !== want_v.len)
                begin
                    $display("%0t name_length mismatch: expected %0d actual %0d",
                             $time, want_v.len, name_length);
                    errors++;
                end
            end
        end
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && !(req_valid && req_ready) && !(result_valid && result_ready))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int         sent;
        bit         long_first;
        logic [7:0] nl;
        logic [5:0] ll;
        clear_hostname();
        send_idle_pct = 38;
        recv_idle_pct = 49;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].verdict);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_idle();
            case (phase * 3 / NUM_PHASES)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                1:
                begin
                    nl = 8'd255;
                    ll = 6'd63;
                end
                2:
                begin
                    nl = 8'd1;
                    ll = 6'd1;
                end
                3:
                begin
                    nl = 8'd0;
                    ll = 6'd0;
                end
                4:
                begin
                    nl = 8'd20;
                    ll = 6'd5;
                end
                5:
                begin
                    nl = 8'($urandom_range(8, 255));
                    ll = 6'($urandom_range(2, 63));
                end
                default:
                begin
                    nl = dnsc_pkg::MAX_NAME_RESET;
                    ll = dnsc_pkg::MAX_LABEL_RESET;
                end
            endcase
            if (phase != 0)
                write_limits(nl, {2'($urandom), ll});

            sent = 0;
            long_first = (phase == 1 || phase == 5);
            while (sent < ITEMS_PER_PHASE)
            begin
                build_name(long_first);
                long_first = 1'b0;
                foreach (name_buf[k])
                begin
                    send_request(name_buf[k], 1'b0, '0);
                    sent++;
                end
            end
        end

        wait_idle();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/dnsc_pkg.sv
rtl/core/domain_name_syntax_check_top.sv
tb/domain_name_syntax_check_top_test.sv
